// ===== src/iti_pkg.sv =====
// ----------------------------------------------------------------------------
// iti_pkg: shared types and constants for the iron thermostat idle manager
// Holds field widths, register indexes, converter scaling and the structs
// that pass between the register file, the control core and the top level.
// ----------------------------------------------------------------------------
package iti_pkg;

  // Converter resolution
  localparam int ADC_BITS = 10;

  // Field widths
  localparam int TEMP_W   = 9;
  localparam int SMIN_W   = 3;
  localparam int OMIN_W   = 4;
  localparam int HYST_W   = 6;
  localparam int TICK_W   = 16;
  localparam int MEAS_W   = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MINUTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MINUTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MIN  = 3'd5;

  // Register reset values
  localparam logic [TEMP_W-1:0] RST_SETPOINT       = 9'd50;
  localparam logic [TEMP_W-1:0] RST_SLEEP_SETPOINT = 9'd180;
  localparam logic [SMIN_W-1:0] RST_SLEEP_MINUTES  = 3'd1;
  localparam logic [OMIN_W-1:0] RST_OFF_MINUTES    = 4'd1;
  localparam logic [HYST_W-1:0] RST_HYSTERESIS     = 6'd4;
  localparam logic [TICK_W-1:0] RST_TICKS_PER_MIN  = 16'd60000;

  // Setpoint limits, sleep minute ceiling and docked minute ceiling
  localparam logic [TEMP_W-1:0] SETPOINT_MIN  = 9'd50;
  localparam logic [TEMP_W-1:0] SETPOINT_MAX  = 9'd450;
  localparam logic [SMIN_W-1:0] SLEEP_MIN_MAX = 3'd5;
  localparam logic [OMIN_W-1:0] MINUTES_MAX   = 4'd15;

  // Temperature scaling: floor(adc * 98 / 100) as adc * 513803 >> 19
  localparam int MEAS_MULT  = 513803;
  localparam int MEAS_SHIFT = 19;
  localparam int MEAS_MULT_W = 20;
  localparam int QUOT_W     = ADC_BITS + 2;
  localparam int PROD_W     = MEAS_SHIFT + QUOT_W;
  localparam logic [QUOT_W-1:0] MEAS_MAX = QUOT_W'(1023);

  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic [TEMP_W-1:0] sleep_setpoint;
    logic [SMIN_W-1:0] sleep_minutes;
    logic [OMIN_W-1:0] off_minutes;
    logic [HYST_W-1:0] hysteresis;
    logic [TICK_W-1:0] ticks_per_minute;
  } cfg_t;

  typedef struct packed {
    logic                docked;
    logic                off_button;
    logic [ADC_BITS-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic              heater_on;
    logic              power_off;
    logic              backlight_on;
    logic              asleep;
    logic [SMIN_W-1:0] sleep_left;
    logic [OMIN_W-1:0] off_left;
    logic [MEAS_W-1:0] measured_temp;
  } result_t;

endpackage

// ===== src/iti_if.sv =====
// ----------------------------------------------------------------------------
// iti_if: tick and result channels
// Valid/ready channels carrying one tick sample in and one control result out.
// ----------------------------------------------------------------------------
interface iti_in_if import iti_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                docked;
  logic                off_button;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, docked, off_button, adc_sample, input ready);
  modport sink   (input valid, docked, off_button, adc_sample, output ready);
endinterface

interface iti_out_if import iti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              heater_on;
  logic              power_off;
  logic              backlight_on;
  logic              asleep;
  logic [SMIN_W-1:0] sleep_left;
  logic [OMIN_W-1:0] off_left;
  logic [MEAS_W-1:0] measured_temp;

  modport source (output valid, heater_on, power_off, backlight_on, asleep,
                  sleep_left, off_left, measured_temp, input ready);
  modport sink   (input valid, heater_on, power_off, backlight_on, asleep,
                  sleep_left, off_left, measured_temp, output ready);
endinterface

// ===== src/iron_thermostat_idle_manager.sv =====
// ----------------------------------------------------------------------------
// iron_thermostat_idle_manager: soldering iron thermostat with idle handling
// Input register, control core with combinational result, and output register.
//
//   channel   direction  payload
//   in_item   in         docked, off_button, adc_sample
//   result    out        heater_on, power_off, backlight_on, asleep,
//                        sleep_left, off_left, measured_temp
//   cfg_*     in         write enable, register index, write data
//
// One transaction per cycle sustained while the result channel is ready; a
// sample is taken into the input register, then its result into the output
// register, from which it leaves when the receiver is ready.
// Reset clears the control state and loads the register defaults; no sweep.
// A stalled result holds in the output register while the input register
// still takes one more sample; the core steps only when the result can move.
// ----------------------------------------------------------------------------
module iron_thermostat_idle_manager import iti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  iti_in_if.sink               in_item,
  iti_out_if.source            result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t core_res, out_res;
  logic    out_valid;
  logic    advance;

  iti_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  iti_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Move a sample into the output register when it is free
  assign advance       = s1_valid && (!out_valid || result.ready);
  assign in_item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_item.docked     <= in_item.docked;
      s1_item.off_button <= in_item.off_button;
      s1_item.adc_sample <= in_item.adc_sample;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  // Drive the result channel
  assign result.valid         = out_valid;
  assign result.heater_on     = out_res.heater_on;
  assign result.power_off     = out_res.power_off;
  assign result.backlight_on  = out_res.backlight_on;
  assign result.asleep        = out_res.asleep;
  assign result.sleep_left    = out_res.sleep_left;
  assign result.off_left      = out_res.off_left;
  assign result.measured_temp = out_res.measured_temp;

endmodule

// ===== src/iti_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// iti_cfg_regs: configuration register file
// Six write-only registers loaded by index; fields are truncated to width.
// ----------------------------------------------------------------------------
module iti_cfg_regs import iti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  // Load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint         <= RST_SETPOINT;
      cfg.sleep_setpoint   <= RST_SLEEP_SETPOINT;
      cfg.sleep_minutes    <= RST_SLEEP_MINUTES;
      cfg.off_minutes      <= RST_OFF_MINUTES;
      cfg.hysteresis       <= RST_HYSTERESIS;
      cfg.ticks_per_minute <= RST_TICKS_PER_MIN;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SETPOINT:       cfg.setpoint         <= cfg_data[TEMP_W-1:0];
        REG_SLEEP_SETPOINT: cfg.sleep_setpoint   <= cfg_data[TEMP_W-1:0];
        REG_SLEEP_MINUTES:  cfg.sleep_minutes    <= cfg_data[SMIN_W-1:0];
        REG_OFF_MINUTES:    cfg.off_minutes      <= cfg_data[OMIN_W-1:0];
        REG_HYSTERESIS:     cfg.hysteresis       <= cfg_data[HYST_W-1:0];
        REG_TICKS_PER_MIN:  cfg.ticks_per_minute <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/iti_core.sv =====
// ----------------------------------------------------------------------------
// iti_core: thermostat and docked-idle control
// Scales the sample to degrees, runs the docked minute timer, picks the
// active target and applies the hysteresis heater rule and power-off latch.
// State advances once per transaction when step is high.
// ----------------------------------------------------------------------------
module iti_core import iti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic              tracking, tracking_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [OMIN_W-1:0] minutes_docked, minutes_docked_next;
  logic              heater_state, heater_state_next;
  logic              power_latch, power_latch_next;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [MEAS_W-1:0] measured;
  logic [TEMP_W-1:0] work_target, target;
  logic [SMIN_W-1:0] slp_cfg, sleep_left;
  logic [OMIN_W-1:0] off_left;
  logic [TICK_W-1:0] tpm;
  logic [TICK_W:0]   tick_inc;
  logic              asleep;
  logic              heat_on_cond, heat_off_cond;

  // Scale the converter reading: floor(adc * 98 / 100), saturate at 1023
  always_comb begin
    prod = PROD_W'(item.adc_sample) * PROD_W'(MEAS_MULT_W'(MEAS_MULT));
    quot = prod[MEAS_SHIFT +: QUOT_W];
    measured = (quot > MEAS_MAX) ? MEAS_MAX[MEAS_W-1:0] : quot[MEAS_W-1:0];
  end

  // Clamp configuration values
  always_comb begin
    work_target = (cfg.setpoint < SETPOINT_MIN || cfg.setpoint > SETPOINT_MAX)
                  ? SETPOINT_MIN : cfg.setpoint;
    slp_cfg = (cfg.sleep_minutes > SLEEP_MIN_MAX) ? SLEEP_MIN_MAX : cfg.sleep_minutes;
    tpm = (cfg.ticks_per_minute == '0) ? TICK_W'(1) : cfg.ticks_per_minute;
  end

  // Advance the docked timer
  always_comb begin
    tick_inc            = {1'b0, tick_count} + (TICK_W+1)'(1);
    tracking_next       = 1'b0;
    tick_count_next     = '0;
    minutes_docked_next = '0;
    if (item.docked) begin
      tracking_next = 1'b1;
      if (tracking) begin
        if (tick_inc >= {1'b0, tpm}) begin
          minutes_docked_next = (minutes_docked < MINUTES_MAX)
                                ? minutes_docked + OMIN_W'(1) : minutes_docked;
        end else begin
          tick_count_next     = tick_inc[TICK_W-1:0];
          minutes_docked_next = minutes_docked;
        end
      end
    end
  end

  // Remaining minutes, sleep and target selection
  always_comb begin
    if (tracking_next) begin
      sleep_left = ({1'b0, slp_cfg} > minutes_docked_next)
                   ? SMIN_W'({1'b0, slp_cfg} - minutes_docked_next) : '0;
      off_left   = (cfg.off_minutes > minutes_docked_next)
                   ? cfg.off_minutes - minutes_docked_next : '0;
    end else begin
      sleep_left = slp_cfg;
      off_left   = cfg.off_minutes;
    end
    asleep = tracking_next && (sleep_left == '0);
    target = asleep ? cfg.sleep_setpoint : work_target;
  end

  // Heater hysteresis rule and power-off latch
  always_comb begin
    heat_on_cond  = ({1'b0, measured} + (MEAS_W+1)'(cfg.hysteresis))
                    <= (MEAS_W+1)'(target);
    heat_off_cond = (MEAS_W+1)'(measured)
                    >= ((MEAS_W+1)'(target) + (MEAS_W+1)'(cfg.hysteresis));
    heater_state_next = heat_off_cond ? 1'b0 : (heat_on_cond ? 1'b1 : heater_state);
    power_latch_next  = power_latch || item.off_button ||
                        (tracking_next && (off_left == '0));
  end

  // Result fields
  always_comb begin
    res.heater_on     = heater_state_next;
    res.power_off     = power_latch_next;
    res.backlight_on  = !asleep;
    res.asleep        = asleep;
    res.sleep_left    = sleep_left;
    res.off_left      = off_left;
    res.measured_temp = measured;
  end

  // Hold state between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking       <= 1'b0;
      tick_count     <= '0;
      minutes_docked <= '0;
      heater_state   <= 1'b0;
      power_latch    <= 1'b0;
    end else if (step) begin
      tracking       <= tracking_next;
      tick_count     <= tick_count_next;
      minutes_docked <= minutes_docked_next;
      heater_state   <= heater_state_next;
      power_latch    <= power_latch_next;
    end
  end

endmodule

// ===== sim/iti_control_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iti_control_checker: tick-to-control predictor and result comparator
// Watches the tick channel, the result channel and the register write port.
// Each accepted tick is run through a local thermostat and idle-timer model.
// The predicted control word is queued, and each result transaction is
// compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module iti_control_checker import iti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  iti_in_if                    tick_mon,
  iti_out_if                   ctl_mon,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   failures,
  output int                   pending,
  output int                   checked
);

  // Local copy of the register file
  logic [TEMP_W-1:0] setpoint_r;
  logic [TEMP_W-1:0] sleep_setpoint_r;
  logic [SMIN_W-1:0] sleep_minutes_r;
  logic [OMIN_W-1:0] off_minutes_r;
  logic [HYST_W-1:0] hysteresis_r;
  logic [TICK_W-1:0] ticks_per_min_r;

  // Local copy of the control state
  logic              tracking_r;
  logic [TICK_W-1:0] tick_r;
  logic [OMIN_W-1:0] minutes_r;
  logic              heater_r;
  logic              latch_r;

  // Control words predicted for ticks that are still in flight
  result_t control_q[$];

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                checked, name, got, want));
  endtask

  // Advance the thermostat by one tick and return its control word
  function automatic result_t thermostat_step(item_t t);
    result_t     r;
    int unsigned meas;
    int unsigned work;
    int unsigned nap_min;
    int unsigned tpm;
    int unsigned sleft;
    int unsigned oleft;
    int unsigned target;
    logic        nap;
    tpm  = (ticks_per_min_r == '0) ? 1 : int'(ticks_per_min_r);
    meas = (int'(t.adc_sample) * 98) / 100;
    if (meas > 1023) meas = 1023;
    // Out-of-range setpoint falls back to the minimum; sleep minutes clamp
    work = (setpoint_r < SETPOINT_MIN || setpoint_r > SETPOINT_MAX) ?
           int'(SETPOINT_MIN) : int'(setpoint_r);
    nap_min = (sleep_minutes_r > SLEEP_MIN_MAX) ? int'(SLEEP_MIN_MAX) :
              int'(sleep_minutes_r);

    // Docked timing: start on the docking tick, then count ticks and minutes
    if (t.docked) begin
      if (tracking_r) begin
        if (int'(tick_r) + 1 >= tpm) begin
          tick_r = '0;
          if (minutes_r < MINUTES_MAX) minutes_r = minutes_r + 1'b1;
        end else begin
          tick_r = tick_r + 1'b1;
        end
      end else begin
        tracking_r = 1'b1;
        tick_r     = '0;
        minutes_r  = '0;
      end
    end else begin
      tracking_r = 1'b0;
      tick_r     = '0;
      minutes_r  = '0;
    end

    if (tracking_r) begin
      sleft = (nap_min > minutes_r) ? nap_min - minutes_r : 0;
      oleft = (off_minutes_r > minutes_r) ? int'(off_minutes_r) - minutes_r : 0;
    end else begin
      sleft = nap_min;
      oleft = off_minutes_r;
    end

    nap    = tracking_r && (sleft == 0);
    target = nap ? int'(sleep_setpoint_r) : work;

    // Latch power off on timeout or button
    if ((tracking_r && oleft == 0) || t.off_button) latch_r = 1'b1;

    // Bang-bang band; turning off wins when both edges hold
    if (meas + hysteresis_r <= target) heater_r = 1'b1;
    if (meas >= target + hysteresis_r) heater_r = 1'b0;

    r.heater_on     = heater_r;
    r.power_off     = latch_r;
    r.backlight_on  = !nap;
    r.asleep        = nap;
    r.sleep_left    = SMIN_W'(sleft);
    r.off_left      = OMIN_W'(oleft);
    r.measured_temp = MEAS_W'(meas);
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   tick;
    result_t want;
    if (rst) begin
      setpoint_r       = RST_SETPOINT;
      sleep_setpoint_r = RST_SLEEP_SETPOINT;
      sleep_minutes_r  = RST_SLEEP_MINUTES;
      off_minutes_r    = RST_OFF_MINUTES;
      hysteresis_r     = RST_HYSTERESIS;
      ticks_per_min_r  = RST_TICKS_PER_MIN;
      tracking_r       = 1'b0;
      tick_r           = '0;
      minutes_r        = '0;
      heater_r         = 1'b0;
      latch_r          = 1'b0;
      control_q.delete();
      failures         = 0;
      checked          = 0;
    end else begin
      // Track register writes
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SETPOINT:       setpoint_r       = cfg_data[TEMP_W-1:0];
          REG_SLEEP_SETPOINT: sleep_setpoint_r = cfg_data[TEMP_W-1:0];
          REG_SLEEP_MINUTES:  sleep_minutes_r  = cfg_data[SMIN_W-1:0];
          REG_OFF_MINUTES:    off_minutes_r    = cfg_data[OMIN_W-1:0];
          REG_HYSTERESIS:     hysteresis_r     = cfg_data[HYST_W-1:0];
          REG_TICKS_PER_MIN:  ticks_per_min_r  = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end

      // Predict on each accepted tick transaction
      if (tick_mon.valid && tick_mon.ready) begin
        tick.docked     = tick_mon.docked;
        tick.off_button = tick_mon.off_button;
        tick.adc_sample = tick_mon.adc_sample;
        control_q.push_back(thermostat_step(tick));
      end

      // Compare each accepted result transaction with the oldest prediction
      if (ctl_mon.valid && ctl_mon.ready) begin
        if (control_q.size() == 0) begin
          report_mismatch("result transaction with no tick in flight");
        end else begin
          want = control_q.pop_front();
          check_field("heater_on",     ctl_mon.heater_on,     want.heater_on);
          check_field("power_off",     ctl_mon.power_off,     want.power_off);
          check_field("backlight_on",  ctl_mon.backlight_on,  want.backlight_on);
          check_field("asleep",        ctl_mon.asleep,        want.asleep);
          check_field("sleep_left",    ctl_mon.sleep_left,    want.sleep_left);
          check_field("off_left",      ctl_mon.off_left,      want.off_left);
          check_field("measured_temp", ctl_mon.measured_temp, want.measured_temp);
          checked++;
        end
      end
    end
    pending <= control_q.size();
  end

endmodule

// ===== sim/tb_iron_thermostat_idle_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iron_thermostat_idle_manager: stimulus and verdict for the thermostat
// Drives directed ticks through clamped and extreme register settings, then
// random docking sequences with temperatures around the heater band, under
// sender and receiver stalls. The checker beside the block predicts and
// compares every result; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_iron_thermostat_idle_manager;
  import iti_pkg::*;

  localparam int CLK_HALF_NS = 10;
  localparam int LIMIT_NS    = 5_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 50;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int failures;
  int pending;
  int checked;

  int send_idle;
  int recv_idle;
  int items_sent;
  int settings_loaded;

  // Register values in force, used to shape the stimulus
  int cur_sp;
  int cur_ssp;
  int cur_hyst;

  iti_in_if  in_ch();
  iti_out_if res_ch();

  iron_thermostat_idle_manager DUT (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_ch),
    .result       (res_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  iti_control_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .tick_mon     (in_ch),
    .ctl_mon      (res_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Receiver: stall at random at the current rate
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #LIMIT_NS;
    $display("Timeout after %0d ns with %0d results in flight", LIMIT_NS, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one tick, with a random gap ahead of it, and hold until accepted
  task automatic send_tick(logic dock, logic btn, logic [ADC_BITS-1:0] adc);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid      <= 1'b1;
    in_ch.docked     <= dock;
    in_ch.off_button <= btn;
    in_ch.adc_sample <= adc;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every result has drained
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= CFG_W'(val);
    @(posedge clk);
  endtask

  // Drain, then write all six registers back to back
  task automatic load_settings(int sp, int ssp, int smin, int omin, int hy, int tpm);
    settle();
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_SLEEP_SETPOINT, ssp);
    write_reg(REG_SLEEP_MINUTES, smin);
    write_reg(REG_OFF_MINUTES, omin);
    write_reg(REG_HYSTERESIS, hy);
    write_reg(REG_TICKS_PER_MIN, tpm);
    cfg_write_en <= 1'b0;
    cur_sp   = (sp < SETPOINT_MIN || sp > SETPOINT_MAX) ? int'(SETPOINT_MIN) : sp;
    cur_ssp  = ssp;
    cur_hyst = hy;
    settings_loaded++;
  endtask

  // Random docking runs, mostly with temperatures near the active band
  task automatic run_random(int n);
    logic dock;
    int   run_left;
    int   sel;
    int   temp;
    int   adc;
    dock     = 1'b0;
    run_left = 0;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        dock     = !dock;
        run_left = dock ? $urandom_range(1, 30) : $urandom_range(1, 6);
      end
      run_left--;
      sel = $urandom_range(99);
      if (sel < 55) begin
        temp = ($urandom_range(1) ? cur_sp : cur_ssp) - (cur_hyst + 3) +
               $urandom_range(0, 2 * (cur_hyst + 3));
        if (temp < 0) temp = 0;
        adc = (temp * 100 + 97) / 98;
        if (adc > 1023) adc = 1023;
      end else if (sel < 90) begin
        adc = $urandom_range(1023);
      end else begin
        adc = sel[0] ? 1023 : 0;
      end
      send_tick(dock, $urandom_range(99) < 3, ADC_BITS'(adc));
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_write_en     <= 1'b0;
    cfg_index        <= REG_SETPOINT;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.docked     <= 1'b0;
    in_ch.off_button <= 1'b0;
    in_ch.adc_sample <= '0;
    send_idle       = 16;
    recv_idle       = 83;
    items_sent      = 0;
    settings_loaded = 0;
    cur_sp   = RST_SETPOINT;
    cur_ssp  = RST_SLEEP_SETPOINT;
    cur_hyst = RST_HYSTERESIS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: converter extremes and both heater band edges
    send_tick(1'b0, 1'b0, 10'd0);
    send_tick(1'b0, 1'b0, 10'd1023);
    send_tick(1'b0, 1'b0, 10'd47);
    send_tick(1'b0, 1'b0, 10'd55);
    send_tick(1'b0, 1'b0, 10'd56);
    send_tick(1'b1, 1'b0, 10'd52);
    send_tick(1'b1, 1'b0, 10'd512);
    send_tick(1'b0, 1'b0, 10'd1023);

    // Readings just below a whole degree near the top of the scale
    send_tick(1'b0, 1'b0, 10'd901);
    send_tick(1'b0, 1'b0, 10'd951);
    send_tick(1'b0, 1'b0, 10'd1001);

    // Setpoint below range, sleep setpoint above range, sleep minutes clamped,
    // one tick per minute: dock until sleep, then lift
    load_settings(49, 511, 7, 15, 63, 1);
    for (int k = 0; k < 8; k++)
      send_tick(1'b1, 1'b0, k[0] ? 10'd1023 : 10'd0);
    send_tick(1'b0, 1'b0, 10'd300);

    // Setpoint above range, zero sleep and off minutes, zero ticks per minute,
    // then the off button
    load_settings(451, 0, 0, 0, 0, 0);
    send_tick(1'b1, 1'b0, 10'd0);
    send_tick(1'b1, 1'b0, 10'd1);
    send_tick(1'b0, 1'b1, 10'd1023);
    send_tick(1'b0, 1'b1, 10'd0);
    send_tick(1'b1, 1'b0, 10'd51);

    // Random phases: extreme settings first, then random ones
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        send_idle = 83;
        recv_idle = 16;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 0)
        load_settings(450, 0, 5, 15, 63, 2);
      else if (p == 1)
        load_settings(50, 450, 1, 1, 0, 65535);
      else
        load_settings($urandom_range(511), $urandom_range(511), $urandom_range(7),
                      $urandom_range(15), $urandom_range(63), $urandom_range(0, 5));
      run_random(PHASE_TICKS);
    end

    settle();
    $display("Sent %0d ticks over %0d register settings; %0d results compared.",
             items_sent, settings_loaded, checked);
    $display("Covered docking, sleep, power-off latch, band edges and clamped settings.");
    if (failures == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
src/iti_pkg.sv
src/iti_if.sv
src/iti_cfg_regs.sv
src/iti_core.sv
src/iron_thermostat_idle_manager.sv
sim/iti_control_checker.sv
sim/tb_iron_thermostat_idle_manager.sv
